// ----- hw/rtl/icp_pkg.sv -----
// Package with shared types, constants and color helpers for the icon pixel converter.
`timescale 1ns / 1ps

package icp_pkg;

    localparam int PALETTE_DEPTH_DEF = 256;
    localparam logic [31:0] SPREAD_MASK = 32'h07E0_F81F;
    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [7:0] ALPHA_CLEAR = 8'h00;

    typedef enum logic [1:0] {
        FMT_4BPP   = 2'd0,
        FMT_8BPP   = 2'd1,
        FMT_RGB24  = 2'd2,
        FMT_ARGB32 = 2'd3
    } t_fmt;

    typedef enum logic {
        OP_PAL_WRITE = 1'b0,
        OP_PIXEL     = 1'b1
    } t_op;

    typedef enum logic {
        CFG_FORMAT = 1'b0,
        CFG_BG     = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0] pal;
        logic [15:0] px;
        logic [7:0]  alpha;
        logic        mask;
        logic        oob;
    } t_s1;

    typedef struct packed {
        logic [15:0] colour;
        logic        blend;
        logic [31:0] diff;
        logic [31:0] b2;
        logic [4:0]  w;
    } t_s2;

    function automatic logic [15:0] pack565(input logic [7:0] r, input logic [7:0] g,
                                            input logic [7:0] b);
        pack565 = {r[7:3], g[7:2], b[7:3]};
    endfunction

    function automatic logic [31:0] spread565(input logic [15:0] c);
        spread565 = {c, c} & SPREAD_MASK;
    endfunction

endpackage

// ----- hw/rtl/icp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module icp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/icp_lookup.sv -----
// Input stage: palette writes, palette read and packing of the direct color.
`timescale 1ns / 1ps

module icp_lookup import icp_pkg::*; #(
    parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_op        i_op,
    input  logic [7:0] i_palette_index,
    input  logic [7:0] i_red,
    input  logic [7:0] i_green,
    input  logic [7:0] i_blue,
    input  logic [7:0] i_alpha,
    input  logic       i_mask_bit,
    input  t_fmt       i_format,
    output logic       o_valid,
    input  logic       i_ready,
    output t_s1        o_s1
);

    localparam int AW = $clog2(PALETTE_DEPTH);
    localparam logic [8:0] DEPTH_W = 9'(PALETTE_DEPTH);

    logic        w_accept;
    logic        w_oob;
    logic [7:0]  w_rd_idx;
    logic [15:0] w_pal;
    logic        r_valid, n_valid;
    logic [15:0] r_px;
    logic [7:0]  r_alpha;
    logic        r_mask;
    logic        r_oob;

    assign o_ready  = !r_valid || i_ready;
    assign w_accept = i_valid && o_ready;
    assign w_oob    = {1'b0, i_palette_index} >= DEPTH_W;
    assign w_rd_idx = (i_format == FMT_4BPP) ? {4'b0, i_palette_index[3:0]} : i_palette_index;

    icp_ram #(
        .WIDTH(16),
        .DEPTH(PALETTE_DEPTH)
    ) u_palette (
        .i_clk  (i_clk),
        .i_we   (w_accept && (i_op == OP_PAL_WRITE) && !w_oob),
        .i_waddr(i_palette_index[AW-1:0]),
        .i_wdata(pack565(i_red, i_green, i_blue)),
        .i_re   (w_accept && (i_op == OP_PIXEL)),
        .i_raddr(w_rd_idx[AW-1:0]),
        .o_rdata(w_pal)
    );

    always_comb begin
        n_valid = r_valid;
        if (o_ready) begin
            n_valid = w_accept && (i_op == OP_PIXEL);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && (i_op == OP_PIXEL)) begin
            r_px    <= pack565(i_red, i_green, i_blue);
            r_alpha <= i_alpha;
            r_mask  <= i_mask_bit;
            r_oob   <= w_oob;
        end
    end

    assign o_valid = r_valid;
    assign o_s1    = '{pal: w_pal, px: r_px, alpha: r_alpha, mask: r_mask, oob: r_oob};

endmodule

// ----- hw/rtl/icp_select.sv -----
// Format selection stage: picks the color and prepares the blend operands.
`timescale 1ns / 1ps

module icp_select import icp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_s1         i_s1,
    input  t_fmt        i_format,
    input  logic [15:0] i_bg,
    output logic        o_valid,
    input  logic        i_ready,
    output t_s2         o_s2
);

    logic r_valid;
    t_s2  r_s2, n_s2;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        n_s2.blend  = 1'b0;
        n_s2.b2     = spread565(i_bg);
        n_s2.diff   = spread565(i_s1.px) - n_s2.b2;
        n_s2.w      = i_s1.alpha[7:3];
        case (i_format)
            FMT_4BPP:  n_s2.colour = i_s1.mask ? i_bg : i_s1.pal;
            FMT_8BPP:  n_s2.colour = i_s1.mask ? i_bg : (i_s1.oob ? 16'h0 : i_s1.pal);
            FMT_RGB24: n_s2.colour = i_s1.mask ? i_bg : i_s1.px;
            FMT_ARGB32: begin
                if (i_s1.alpha == ALPHA_OPAQUE) begin
                    n_s2.colour = i_s1.px;
                end else if (i_s1.alpha == ALPHA_CLEAR) begin
                    n_s2.colour = i_bg;
                end else begin
                    n_s2.colour = i_s1.px;
                    n_s2.blend  = 1'b1;
                end
            end
            default:   n_s2.colour = i_s1.px;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_s2 <= n_s2;
        end
    end

    assign o_valid = r_valid;
    assign o_s2    = r_s2;

endmodule

// ----- hw/rtl/icp_blend.sv -----
// Blend multiply stage and output register stage.
`timescale 1ns / 1ps

module icp_blend import icp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_s2         i_s2,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_pixel_565
);

    logic        r_valid3;
    logic [31:0] r_prod;
    logic [31:0] r_b2;
    logic [15:0] r_colour;
    logic        r_blend;
    logic        w_en_out;
    logic [31:0] w_mix;
    logic [15:0] n_pixel;
    logic        r_valid_out;
    logic [15:0] r_pixel;

    assign w_en_out = !r_valid_out || i_ready;
    assign o_ready  = !r_valid3 || w_en_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid3 <= 1'b0;
        end else if (o_ready) begin
            r_valid3 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_prod   <= 32'(i_s2.diff * {27'b0, i_s2.w});
            r_b2     <= i_s2.b2;
            r_colour <= i_s2.colour;
            r_blend  <= i_s2.blend;
        end
    end

    assign w_mix   = ((r_prod >> 5) + r_b2) & SPREAD_MASK;
    assign n_pixel = r_blend ? (w_mix[31:16] | w_mix[15:0]) : r_colour;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_out <= 1'b0;
        end else if (w_en_out) begin
            r_valid_out <= r_valid3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_out && r_valid3) begin
            r_pixel <= n_pixel;
        end
    end

    assign o_valid     = r_valid_out;
    assign o_pixel_565 = r_pixel;

endmodule

// ----- hw/rtl/icon_pixel_to_rgb565.sv -----
// Top level of the icon pixel to RGB565 converter.
// The block takes one transaction per clock while the output accepts, palette writes and
// pixels alike, and every pixel transaction returns one RGB565 color; palette writes
// produce no output. Pixels pass a four-stage pipeline: palette read, format selection,
// blend multiply and output register, each of which holds its item under backpressure
// without loss. A palette write is visible to the next pixel transaction. Configuration
// is written through a plain write port; the user must do so only while the block is
// idle, as the block does not enforce it. The palette is undefined until written.
`timescale 1ns / 1ps

module icon_pixel_to_rgb565 import icp_pkg::*; #(
    parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // palette_index[7:0], red[15:8], green[23:16], blue[31:24], alpha[39:32],
    // mask_bit[40], zero fill [47:41]
    input  logic [47:0] s_axis_tdata,
    // operation[0]
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // pixel_565[15:0]
    output logic [15:0] m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_fmt        r_format;
    logic [15:0] r_bg;
    logic        w_v1, w_r1, w_v2, w_r2;
    t_s1         w_s1;
    t_s2         w_s2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format <= FMT_8BPP;
            r_bg     <= 16'h0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_FORMAT: r_format <= t_fmt'(i_cfg_data[1:0]);
                CFG_BG:     r_bg     <= i_cfg_data;
                default:    r_bg     <= r_bg;
            endcase
        end
    end

    icp_lookup #(
        .PALETTE_DEPTH(PALETTE_DEPTH)
    ) u_lookup (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (s_axis_tvalid),
        .o_ready        (s_axis_tready),
        .i_op           (t_op'(s_axis_tuser)),
        .i_palette_index(s_axis_tdata[7:0]),
        .i_red          (s_axis_tdata[15:8]),
        .i_green        (s_axis_tdata[23:16]),
        .i_blue         (s_axis_tdata[31:24]),
        .i_alpha        (s_axis_tdata[39:32]),
        .i_mask_bit     (s_axis_tdata[40]),
        .i_format       (r_format),
        .o_valid        (w_v1),
        .i_ready        (w_r1),
        .o_s1           (w_s1)
    );

    icp_select u_select (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_v1),
        .o_ready (w_r1),
        .i_s1    (w_s1),
        .i_format(r_format),
        .i_bg    (r_bg),
        .o_valid (w_v2),
        .i_ready (w_r2),
        .o_s2    (w_s2)
    );

    icp_blend u_blend (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_v2),
        .o_ready    (w_r2),
        .i_s2       (w_s2),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_pixel_565(m_axis_tdata)
    );

endmodule

// ----- dv/icon_pixel_to_rgb565_checker.sv -----
// Checker for the icon pixel converter: predicts each RGB565 result and compares it.
`timescale 1ns / 1ps

module icon_pixel_to_rgb565_checker import icp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    // palette_index[7:0], red[15:8], green[23:16], blue[31:24], alpha[39:32],
    // mask_bit[40], zero fill [47:41]
    input  logic [47:0] s_axis_tdata,
    // operation[0]
    input  logic        s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // pixel_565[15:0]
    input  logic [15:0] m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output int          o_err_count,
    output int          o_pending
);

    typedef struct packed {
        logic       mask;
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] index;
    } t_pixel_in;

    t_fmt        cur_fmt = FMT_8BPP;
    logic [15:0] cur_bg = 16'h0000;
    logic [15:0] palette [256];
    logic [15:0] colors_due [$];

    initial begin
        o_err_count = 0;
        o_pending = 0;
    end

    function automatic logic [15:0] rgb_to_565(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        return {r[7:3], g[7:2], b[7:3]};
    endfunction

    // The weight applies to the image color; the green field sits in the upper half so
    // that all three channels scale in one 32-bit multiply.
    function automatic logic [15:0] blend_over_bg(logic [15:0] base, logic [15:0] over,
                                                  logic [4:0] w);
        logic [31:0] base_wide;
        logic [31:0] over_wide;
        logic [31:0] mix;
        base_wide = {base, base} & SPREAD_MASK;
        over_wide = {over, over} & SPREAD_MASK;
        mix = ((((over_wide - base_wide) * w) >> 5) + base_wide) & SPREAD_MASK;
        return mix[31:16] | mix[15:0];
    endfunction

    function automatic logic [15:0] predict_color(t_pixel_in px);
        logic [15:0] direct;
        direct = rgb_to_565(px.red, px.green, px.blue);
        case (cur_fmt)
            FMT_4BPP: return px.mask ? cur_bg : palette[{4'h0, px.index[3:0]}];
            FMT_8BPP: return px.mask ? cur_bg : palette[px.index];
            FMT_RGB24: return px.mask ? cur_bg : direct;
            default: begin
                if (px.alpha == ALPHA_OPAQUE) return direct;
                else if (px.alpha == ALPHA_CLEAR) return cur_bg;
                else return blend_over_bg(cur_bg, direct, px.alpha[7:3]);
            end
        endcase
    endfunction

    always @(posedge i_clk) begin : monitor
        t_pixel_in   px;
        logic [15:0] want;
        if (!i_rst_n) begin
            cur_fmt = FMT_8BPP;
            cur_bg = 16'h0000;
            colors_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_FORMAT: cur_fmt = t_fmt'(i_cfg_data[1:0]);
                    CFG_BG: cur_bg = i_cfg_data;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                px = t_pixel_in'(s_axis_tdata[40:0]);
                if (t_op'(s_axis_tuser) == OP_PAL_WRITE) begin
                    palette[px.index] = rgb_to_565(px.red, px.green, px.blue);
                end else begin
                    colors_due.push_back(predict_color(px));
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (colors_due.size() == 0) begin
                    $display("%0t: unexpected pixel_565 transaction: expected none, actual %h",
                             $time, m_axis_tdata);
                    o_err_count = o_err_count + 1;
                end else begin
                    want = colors_due.pop_front();
                    if (m_axis_tdata !== want) begin
                        $display("%0t: pixel_565 mismatch: expected %h, actual %h",
                                 $time, want, m_axis_tdata);
                        o_err_count = o_err_count + 1;
                    end
                end
            end
        end
        o_pending = colors_due.size();
    end

endmodule

// ----- dv/icon_pixel_to_rgb565_test.sv -----
// Testbench top for the icon pixel converter: clock, reset, stimulus, configuration and verdict.
`timescale 1ns / 1ps

module icon_pixel_to_rgb565_test;
    import icp_pkg::*;

    localparam int IDLE_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASES = 12;
    localparam int PHASE_ITEMS = 125;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [15:0] i_cfg_data = '0;

    int          err_count;
    int          pending;
    logic        calm = 1'b0;
    logic        in_taken = 1'b0;
    int          idle_cycles = 0;
    t_fmt        cur_fmt = FMT_8BPP;
    bit          pal_written [256];
    logic [7:0]  written_idx [$];
    logic [3:0]  written_low [$];

    always #4 i_clk = ~i_clk;

    icon_pixel_to_rgb565 DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    icon_pixel_to_rgb565_checker color_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_err_count   (err_count),
        .o_pending     (pending)
    );

    always @(posedge i_clk) begin
        in_taken <= s_axis_tvalid && s_axis_tready;
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int stall;
        forever begin
            @(negedge i_clk);
            if (!calm && $urandom_range(0, 15) == 0) begin
                m_axis_tready <= 1'b0;
                stall = $urandom_range(1, 16);
                repeat (stall) @(negedge i_clk);
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the transaction is taken.
    task automatic send(t_op op, logic [7:0] idx, logic [7:0] r, logic [7:0] g,
                        logic [7:0] b, logic [7:0] a, logic msk);
        s_axis_tuser <= op;
        s_axis_tdata <= {7'd0, msk, a, b, g, r, idx};
        s_axis_tvalid <= 1'b1;
        if (op == OP_PAL_WRITE && !pal_written[idx]) begin
            pal_written[idx] = 1'b1;
            written_idx.push_back(idx);
            if (idx < 8'd16) written_low.push_back(idx[3:0]);
        end
        do @(negedge i_clk); while (!in_taken);
    endtask

    task automatic sender_gap();
        int n;
        if (!calm && $urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 16);
            s_axis_tvalid <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
    endtask

    // Palette writes give no result, so the pipeline gets extra cycles to empty.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_config(t_fmt f, logic [15:0] bg);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_FORMAT;
        i_cfg_data <= {14'd0, f};
        @(negedge i_clk);
        i_cfg_index <= CFG_BG;
        i_cfg_data <= bg;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cur_fmt = f;
    endtask

    // Pixel indexes only ever point at palette entries that have been written.
    task automatic random_item();
        logic [7:0] idx;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
        logic       msk;
        idx = 8'($urandom);
        r = 8'($urandom);
        g = 8'($urandom);
        b = 8'($urandom);
        a = 8'($urandom);
        msk = ($urandom_range(0, 3) == 0);
        case ($urandom_range(0, 9))
            0: {r, g, b} = '0;
            1: {r, g, b} = '1;
            default: ;
        endcase
        if ($urandom_range(0, 3) == 0) begin
            if ($urandom_range(0, 3) == 0) idx[7:4] = 4'h0;
            send(OP_PAL_WRITE, idx, r, g, b, a, msk);
        end else begin
            if (cur_fmt == FMT_4BPP) begin
                idx[3:0] = written_low[$urandom_range(0, written_low.size() - 1)];
            end else begin
                idx = written_idx[$urandom_range(0, written_idx.size() - 1)];
            end
            case ($urandom_range(0, 5))
                0: a = ALPHA_CLEAR;
                1: a = ALPHA_OPAQUE;
                default: ;
            endcase
            send(OP_PIXEL, idx, r, g, b, a, msk);
        end
    endtask

    initial begin
        logic [15:0] bg;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset configuration: 8 bpp indexed over a black background.
        send(OP_PAL_WRITE, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
        send(OP_PAL_WRITE, 8'd255, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        send(OP_PAL_WRITE, 8'd15, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b0);
        send(OP_PAL_WRITE, 8'd16, 8'h00, 8'hFF, 8'h00, 8'hFF, 1'b1);
        send(OP_PAL_WRITE, 8'd170, 8'h07, 8'h03, 8'hFF, 8'h00, 1'b0);
        send(OP_PIXEL, 8'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        send(OP_PIXEL, 8'd255, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
        send(OP_PIXEL, 8'd170, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
        send(OP_PIXEL, 8'd16, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);

        // In 4 bpp only the low nibble of the index selects the entry.
        set_config(FMT_4BPP, 16'hFFFF);
        send(OP_PIXEL, 8'hF0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
        send(OP_PIXEL, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
        send(OP_PIXEL, 8'h0F, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1);

        set_config(FMT_RGB24, 16'hA5A5);
        send(OP_PIXEL, 8'd0, 8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b0);
        send(OP_PIXEL, 8'd0, 8'h00, 8'h00, 8'h00, 8'hFF, 1'b0);
        send(OP_PIXEL, 8'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        send(OP_PAL_WRITE, 8'd1, 8'h12, 8'h34, 8'h56, 8'h00, 1'b0);

        // In 32 bpp the mask is ignored and alpha below 8 leaves only the background.
        set_config(FMT_ARGB32, 16'h0000);
        send(OP_PIXEL, 8'd0, 8'h9C, 8'h5A, 8'h3F, ALPHA_OPAQUE, 1'b1);
        send(OP_PIXEL, 8'd0, 8'hFF, 8'hFF, 8'hFF, ALPHA_CLEAR, 1'b0);
        send(OP_PIXEL, 8'd0, 8'hFF, 8'hFF, 8'hFF, 8'h01, 1'b0);
        send(OP_PIXEL, 8'd0, 8'hFF, 8'hFF, 8'hFF, 8'h08, 1'b1);
        send(OP_PIXEL, 8'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFE, 1'b0);
        set_config(FMT_ARGB32, 16'hFFFF);
        send(OP_PIXEL, 8'd1, 8'h00, 8'h00, 8'h00, 8'h80, 1'b0);
        send(OP_PIXEL, 8'd1, 8'h3C, 8'hC3, 8'h81, 8'h7F, 1'b0);

        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase == 0) bg = 16'h0000;
            else if (phase == 1) bg = 16'hFFFF;
            else bg = 16'($urandom);
            set_config(t_fmt'(phase % 4), bg);
            calm = (phase >= PHASES - 2);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (phase == 5 && n == PHASE_ITEMS / 2) begin
                    s_axis_tvalid <= 1'b0;
                    do @(negedge i_clk); while (pending != 0);
                end
                sender_gap();
                random_item();
            end
        end

        drain();
        if (err_count == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
